// File: hdl/edidbg_pkg.sv
// shared types, constants and mode tables for the edid block generator
`timescale 1ns / 1ps
package edidbg_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int POS_W       = $clog2(BLOCK_BYTES);

    // configuration register indexes
    localparam logic [2:0] CFG_PREF_W  = 3'd0;
    localparam logic [2:0] CFG_PREF_H  = 3'd1;
    localparam logic [2:0] CFG_CEIL_W  = 3'd2;
    localparam logic [2:0] CFG_CEIL_H  = 3'd3;
    localparam logic [2:0] CFG_REFRESH = 3'd4;

    // fixed porches
    localparam logic [7:0] H_BLANK = 8'd160;
    localparam logic [7:0] H_FRONT = 8'd48;
    localparam logic [7:0] H_SYNC  = 8'd32;
    localparam logic [7:0] V_BLANK = 8'd38;
    localparam logic [7:0] V_FS    = 8'h36;   // front 3, sync 6
    localparam logic [7:0] DESC_TAIL = 8'h1e;

    // clock / 10000: saturate at or above 65536 * 10000, else (x >> 4) * ceil(2^36 / 625) >> 36
    localparam logic [33:0] CLK_SAT   = 34'd655360000;
    localparam logic [26:0] RECIP_625 = 27'd109951163;

    // byte positions
    localparam logic [6:0] POS_REV    = 7'd19;
    localparam logic [6:0] POS_FEAT   = 7'd24;
    localparam logic [6:0] POS_EST1   = 7'h23;
    localparam logic [6:0] POS_LADDER = 7'h26;
    localparam logic [6:0] POS_DESC1  = 7'h36;
    localparam logic [6:0] POS_DESC2  = 7'h48;
    localparam logic [6:0] POS_DESC3  = 7'h5a;
    localparam logic [6:0] POS_DESC4  = 7'h6c;
    localparam logic [6:0] POS_END    = 7'h7e;
    localparam logic [6:0] POS_CSUM   = 7'(BLOCK_BYTES - 1);

    typedef struct packed {
        logic load_in;
        logic sel;
        logic mul1;
        logic mul2;
        logic div;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_stat;

    localparam logic [11:0] EST1_W [0:13] = '{720, 640, 640, 640, 800, 800, 800, 800,
                                              832, 1024, 1024, 1024, 1280, 1152};
    localparam logic [11:0] EST1_H [0:13] = '{400, 480, 480, 480, 600, 600, 600, 600,
                                              624, 768, 768, 768, 1024, 870};
    localparam logic [1:0]  EST1_I [0:13] = '{0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 2};
    localparam logic [2:0]  EST1_B [0:13] = '{7, 5, 3, 2, 1, 0, 7, 6, 5, 3, 2, 1, 0, 7};

    // entry i sits in byte i/8, bit 7 - i%8
    localparam logic [11:0] EST3_W [0:43] = '{
        640, 640, 720, 640, 848, 800, 1024, 1152,
        1280, 1280, 1280, 1280, 1280, 1280, 1280, 1280,
        1360, 1440, 1440, 1440, 1440, 1400, 1400, 1400,
        1400, 1680, 1680, 1680, 1680, 1600, 1600, 1600,
        1600, 1600, 1792, 1792, 1856, 1856, 1920, 1920,
        1920, 1920, 1920, 1920};
    localparam logic [11:0] EST3_H [0:43] = '{
        350, 400, 400, 480, 480, 600, 768, 864,
        768, 768, 768, 768, 960, 960, 1024, 1024,
        768, 900, 900, 900, 900, 1050, 1050, 1050,
        1050, 1050, 1050, 1050, 1050, 1200, 1200, 1200,
        1200, 1200, 1344, 1344, 1392, 1392, 1200, 1200,
        1200, 1200, 1440, 1440};

    localparam logic [11:0] LAD_W [0:7] = '{1280, 1440, 1600, 1680, 1920, 1152, 1280, 1280};
    localparam logic [11:0] LAD_H [0:7] = '{1024, 900, 1200, 1050, 1080, 864, 960, 720};
    localparam logic [1:0]  LAD_A [0:7] = '{2, 0, 1, 0, 3, 1, 1, 3};

    localparam logic [11:0] DET_W [0:2] = '{3840, 3440, 2560};
    localparam logic [11:0] DET_H [0:2] = '{2160, 1440, 1440};

    function automatic logic [7:0] est1_byte(input logic [1:0] idx,
                                             input logic [11:0] cw, input logic [11:0] ch);
        logic [7:0] v;
        v = '0;
        for (int i = 0; i < 14; i++) begin
            if (EST1_I[i] == idx && EST1_W[i] <= cw && EST1_H[i] <= ch) begin
                v[EST1_B[i]] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] est3_byte(input logic [2:0] idx,
                                             input logic [11:0] cw, input logic [11:0] ch);
        logic [7:0] v;
        v = '0;
        for (int b = 0; b < 8; b++) begin
            for (int i = 0; i < 44; i++) begin
                if (i == int'(idx) * 8 + 7 - b && EST3_W[i] <= cw && EST3_H[i] <= ch) begin
                    v[b] = 1'b1;
                end
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] ladder_byte(input logic [3:0] off,
                                               input logic [11:0] cw, input logic [11:0] ch);
        logic [7:0] v;
        logic [3:0] found;
        logic       done;
        v = 8'h01;
        found = '0;
        done = 1'b0;
        for (int e = 0; e < 8; e++) begin
            if (!done && LAD_W[e] <= cw && LAD_H[e] <= ch) begin
                if (found == {1'b0, off[3:1]}) begin
                    v = off[0] ? {LAD_A[e], 6'd0} : 8'((LAD_W[e] >> 3) - 12'd31);
                    done = 1'b1;
                end
                found = found + 4'd1;
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] timing_byte(input logic [4:0] k, input logic [11:0] w,
                                               input logic [11:0] h, input logic [15:0] clk);
        logic [7:0] v;
        case (k)
            5'd0:    v = clk[7:0];
            5'd1:    v = clk[15:8];
            5'd2:    v = w[7:0];
            5'd3:    v = H_BLANK;
            5'd4:    v = {w[11:8], 4'd0};
            5'd5:    v = h[7:0];
            5'd6:    v = V_BLANK;
            5'd7:    v = {h[11:8], 4'd0};
            5'd8:    v = H_FRONT;
            5'd9:    v = H_SYNC;
            5'd10:   v = V_FS;
            5'd17:   v = DESC_TAIL;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/edidbg_ctrl.sv
// sequencer for one byte: select mode, two multiplies, scale, emit
`timescale 1ns / 1ps
module edidbg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    input  edidbg_pkg::t_dp_stat i_stat,
    output edidbg_pkg::t_dp_cmd  o_cmd
);
    import edidbg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEL  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic       w_emit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_emit     = (r_state == S_DONE) && (!i_stat.out_full || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SEL;
            S_SEL:   n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_DIV;
            S_DIV:   n_state = S_DONE;
            S_DONE:  if (w_emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.sel      = (r_state == S_SEL);
        o_cmd.mul1     = (r_state == S_MUL1);
        o_cmd.mul2     = (r_state == S_MUL2);
        o_cmd.div      = (r_state == S_DIV);
        o_cmd.load_out = w_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/edidbg_dp.sv
// datapath: config registers, position and sum, dot clock and byte patching
`timescale 1ns / 1ps
module edidbg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_index,
    input  logic [11:0]          i_cfg_data,
    input  logic [7:0]           i_base_byte,
    input  logic                 i_block_start,
    input  edidbg_pkg::t_dp_cmd  i_cmd,
    output edidbg_pkg::t_dp_stat o_stat,
    output logic [7:0]           o_edid_byte,
    output logic                 o_block_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);
    import edidbg_pkg::*;

    logic [11:0] r_pref_w, r_pref_h, r_ceil_w, r_ceil_h;
    logic [7:0]  r_hz;
    logic [6:0]  r_pos, r_cur;
    logic [7:0]  r_sum, r_base;
    logic [11:0] r_tw, r_th;
    logic        r_hit;
    logic [25:0] r_p1;
    logic [33:0] r_p2;
    logic [15:0] r_clk;
    logic [7:0]  r_out;
    logic        r_last, r_valid;

    logic [11:0] w_cw, w_ch;
    logic [2:0]  w_fit;
    logic [1:0]  w_m0, w_m1;
    logic        w_h0, w_h1;
    logic [52:0] w_q;
    logic [7:0]  w_byte;
    logic [6:0]  w_k7;

    assign w_cw = (r_ceil_w < r_pref_w) ? r_pref_w : r_ceil_w;
    assign w_ch = (r_ceil_h < r_pref_h) ? r_pref_h : r_ceil_h;

    // detail-only modes that fit and differ from the preferred one
    always_comb begin
        w_m0 = 2'd0;
        w_m1 = 2'd0;
        w_h0 = 1'b0;
        w_h1 = 1'b0;
        for (int m = 0; m < 3; m++) begin
            w_fit[m] = DET_W[m] <= w_cw && DET_H[m] <= w_ch
                       && !(DET_W[m] == r_pref_w && DET_H[m] == r_pref_h);
        end
        for (int m = 2; m >= 0; m--) begin
            if (w_fit[m]) begin
                w_m1 = w_m0;
                w_h1 = w_h0;
                w_m0 = 2'(m);
                w_h0 = 1'b1;
            end
        end
    end

    assign w_q = {1'b0, r_p2[29:4]} * {26'd0, RECIP_625};

    always_comb begin
        w_byte = r_base;
        w_k7   = '0;
        if (r_cur == POS_CSUM) begin
            w_byte = 8'd0 - r_sum;
        end else if (r_cur == POS_REV) begin
            w_byte = 8'd3;
        end else if (r_cur == POS_FEAT) begin
            w_byte = r_base | 8'h02;
        end else if (r_cur >= POS_EST1 && r_cur < POS_LADDER) begin
            w_k7   = r_cur - POS_EST1;
            w_byte = est1_byte(w_k7[1:0], w_cw, w_ch);
        end else if (r_cur >= POS_LADDER && r_cur < POS_DESC1) begin
            w_k7   = r_cur - POS_LADDER;
            w_byte = ladder_byte(w_k7[3:0], w_cw, w_ch);
        end else if (r_cur >= POS_DESC1 && r_cur < POS_DESC2) begin
            w_k7   = r_cur - POS_DESC1;
            w_byte = timing_byte(w_k7[4:0], r_tw, r_th, r_clk);
        end else if (r_cur >= POS_DESC2 && r_cur < POS_DESC3) begin
            w_k7 = r_cur - POS_DESC2;
            if (w_k7 == 7'd3) begin
                w_byte = 8'hf7;
            end else if (w_k7 == 7'd5) begin
                w_byte = 8'h0a;
            end else if (w_k7 >= 7'd6 && w_k7 < 7'd12) begin
                w_byte = est3_byte(3'(w_k7 - 7'd6), w_cw, w_ch);
            end else begin
                w_byte = 8'd0;
            end
        end else if (r_cur >= POS_DESC3 && r_cur < POS_END) begin
            w_k7 = (r_cur >= POS_DESC4) ? r_cur - POS_DESC4 : r_cur - POS_DESC3;
            if (r_hit) begin
                w_byte = timing_byte(w_k7[4:0], r_tw, r_th, r_clk);
            end
        end
    end

    assign o_stat.out_full = r_valid;
    assign o_edid_byte     = r_out;
    assign o_block_end     = r_last;
    assign o_out_valid     = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pref_w <= 12'd1024;
            r_pref_h <= 12'd768;
            r_ceil_w <= '0;
            r_ceil_h <= '0;
            r_hz     <= 8'd60;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PREF_W:  r_pref_w <= i_cfg_data;
                CFG_PREF_H:  r_pref_h <= i_cfg_data;
                CFG_CEIL_W:  r_ceil_w <= i_cfg_data;
                CFG_CEIL_H:  r_ceil_h <= i_cfg_data;
                CFG_REFRESH: r_hz     <= i_cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in && i_block_start) begin
                r_sum <= '0;
            end
            if (i_cmd.load_out) begin
                r_valid <= 1'b1;
                r_pos   <= r_cur + 7'd1;
                r_sum   <= (r_cur == POS_CSUM) ? 8'd0 : r_sum + w_byte;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur  <= i_block_start ? 7'd0 : r_pos;
            r_base <= i_base_byte;
        end
        if (i_cmd.sel) begin
            if (r_cur < POS_DESC3) begin
                r_tw  <= r_pref_w;
                r_th  <= r_pref_h;
                r_hit <= 1'b1;
            end else if (r_cur < POS_DESC4) begin
                r_tw  <= DET_W[w_m0];
                r_th  <= DET_H[w_m0];
                r_hit <= w_h0;
            end else begin
                r_tw  <= DET_W[w_m1];
                r_th  <= DET_H[w_m1];
                r_hit <= w_h1;
            end
        end
        if (i_cmd.mul1) begin
            r_p1 <= ({1'b0, r_tw} + 13'(H_BLANK)) * ({1'b0, r_th} + 13'(V_BLANK));
        end
        if (i_cmd.mul2) begin
            r_p2 <= {8'd0, r_p1} * {26'd0, r_hz};
        end
        if (i_cmd.div) begin
            r_clk <= (r_p2 >= CLK_SAT) ? 16'hffff : w_q[51:36];
        end
        if (i_cmd.load_out) begin
            r_out  <= w_byte;
            r_last <= (r_cur == POS_CSUM);
        end
    end

endmodule

// File: hdl/edid_block_generator.sv
// top level of the edid base block generator
//
//  channel     dir  width  contents
//  s_axis      in   8+1    tdata base_byte, tuser block_start
//  m_axis      out  8+1    tdata edid_byte, tlast block_end
//  cfg write   in   3+12   register index, write data
//
// every byte steps through accept, mode select, two dot clock multiplies
// (sizes, then refresh), reciprocal scaling by 1/10000, output load
// the single dot clock datapath is shared by all bytes, one byte in flight
// a full output register waiting on m_axis_tready holds the sequencer in its last step
// synchronous active-low reset restores default registers, position 0 and a zero sum
`timescale 1ns / 1ps
module edid_block_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] base_byte
    input  logic        s_axis_tuser,   // [0] block_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] edid_byte
    output logic        m_axis_tlast,   // block_end, on the checksum byte
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import edidbg_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: one transfer in, one byte out
    edidbg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // patching datapath with output register
    edidbg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_base_byte   (s_axis_tdata),
        .i_block_start (s_axis_tuser),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_edid_byte   (m_axis_tdata),
        .o_block_end   (m_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready)
    );

endmodule
